/* rtl/core/smtx_pkg.sv */
package smtx_pkg;

	// Request codes carried by req_type.
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_BYTE = 2'd1;
	localparam logic [1:0] REQ_CC   = 2'd2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_PIN = 2'd1;

	// Register widths and reset values.
	localparam int unsigned PERIOD_W = 16;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd32;
	localparam logic INVERT_RESET = 1'b1;

	// Message and framing constants.
	localparam logic [7:0] CC_STATUS  = 8'hB0;
	localparam logic [7:0] CHAN_MASK  = 8'h0F;
	localparam logic [7:0] DATA7_MASK = 8'h7F;
	localparam int unsigned FRAME_W = 10;
	localparam logic [3:0] FRAME_BITS = 4'd10;
	localparam logic [1:0] QUEUE_FULL = 2'd2;

	// Current configuration handed to the transmit core.
	typedef struct packed {
		logic [PERIOD_W-1:0] bit_period;
		logic                invert_pin;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic pin_level;
		logic line_mark;
		logic busy_res;
		logic dropped;
	} res_t;

endpackage

/* rtl/core/smtx_cfg_regs.sv */
module smtx_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [smtx_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smtx_pkg::PERIOD_W-1:0]    cfg_data,
	output smtx_pkg::cfg_t                   cfg
);
	import smtx_pkg::*;

	logic [PERIOD_W-1:0] bit_period_q;
	logic                invert_pin_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;

	// Register file: writes to unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= PERIOD_RESET;
			invert_pin_q <= INVERT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BIT_PERIOD: bit_period_q <= cfg_data;
				CFG_INVERT_PIN: invert_pin_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.bit_period = bit_period_q;
	assign cfg.invert_pin = invert_pin_q;

endmodule

/* rtl/core/smtx_core.sv */
module smtx_core #(
	parameter int unsigned TICK_COUNTER_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [1:0]            req_type,
	input  logic [7:0]            data_byte,
	input  logic [7:0]            channel,
	input  logic [7:0]            controller,
	input  logic [7:0]            ctrl_value,
	input  smtx_pkg::cfg_t        cfg,
	output smtx_pkg::res_t        res
);
	import smtx_pkg::*;

	localparam int unsigned CMP_W =
		(TICK_COUNTER_BITS > PERIOD_W) ? TICK_COUNTER_BITS : PERIOD_W;

	logic [FRAME_W-1:0]           frame_shift_q, frame_shift_d;
	logic [3:0]                   bits_remaining_q, bits_remaining_d;
	logic [TICK_COUNTER_BITS-1:0] tick_count_q, tick_count_d, tick_next;
	logic                         active_q, active_d;
	logic [1:0]                   queued_count_q, queued_count_d;
	logic                         line_level_q, line_level_d;
	logic [7:0]                   queued0_q, queued1_q;
	logic                         load_queue;
	logic                         dropped_d;
	logic [PERIOD_W-1:0]          period_eff;
	logic [CMP_W-1:0]             next_ext, period_ext;

	// A period of zero behaves as a period of one tick.
	assign period_eff = (cfg.bit_period == '0) ? PERIOD_W'(1) : cfg.bit_period;
	assign tick_next  = tick_count_q + TICK_COUNTER_BITS'(1);
	assign next_ext   = CMP_W'(tick_next);
	assign period_ext = CMP_W'(period_eff);

	// Next state for the accepted item.
	always_comb begin
		frame_shift_d    = frame_shift_q;
		bits_remaining_d = bits_remaining_q;
		tick_count_d     = tick_count_q;
		active_d         = active_q;
		queued_count_d   = queued_count_q;
		line_level_d     = line_level_q;
		load_queue       = 1'b0;
		dropped_d        = 1'b0;
		if (step) begin
			case (req_type)
				REQ_TICK: begin
					if (active_q) begin
						if (tick_next == '0 || next_ext >= period_ext) begin
							// End of a bit period.
							tick_count_d = '0;
							if (bits_remaining_q != 4'd0) begin
								line_level_d     = frame_shift_q[0];
								frame_shift_d    = frame_shift_q >> 1;
								bits_remaining_d = bits_remaining_q - 4'd1;
							end else if (queued_count_q != 2'd0) begin
								queued_count_d   = queued_count_q - 2'd1;
								frame_shift_d    = {1'b1,
									(queued_count_q == QUEUE_FULL) ? queued0_q : queued1_q,
									1'b0};
								bits_remaining_d = FRAME_BITS;
								line_level_d     = 1'b1;
							end else begin
								active_d     = 1'b0;
								line_level_d = 1'b1;
							end
						end else begin
							tick_count_d = tick_next;
						end
					end
				end
				REQ_BYTE, REQ_CC: begin
					if (active_q) begin
						dropped_d = 1'b1;
					end else begin
						bits_remaining_d = FRAME_BITS;
						line_level_d     = 1'b1;
						tick_count_d     = '0;
						active_d         = 1'b1;
						if (req_type == REQ_BYTE) begin
							queued_count_d = 2'd0;
							frame_shift_d  = {1'b1, data_byte, 1'b0};
						end else begin
							load_queue     = 1'b1;
							queued_count_d = QUEUE_FULL;
							frame_shift_d  = {1'b1, CC_STATUS | (channel & CHAN_MASK), 1'b0};
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_shift_q    <= '0;
			bits_remaining_q <= '0;
			tick_count_q     <= '0;
			active_q         <= 1'b0;
			queued_count_q   <= '0;
			line_level_q     <= 1'b1;
		end else begin
			frame_shift_q    <= frame_shift_d;
			bits_remaining_q <= bits_remaining_d;
			tick_count_q     <= tick_count_d;
			active_q         <= active_d;
			queued_count_q   <= queued_count_d;
			line_level_q     <= line_level_d;
		end
	end

	// Queued message bytes hold no reset; they are read only after a write.
	always_ff @(posedge clk) begin
		if (load_queue) begin
			queued0_q <= controller & DATA7_MASK;
			queued1_q <= ctrl_value & DATA7_MASK;
		end
	end

	// Result reflects the state after this item.
	assign res.pin_level = line_level_d ^ cfg.invert_pin;
	assign res.line_mark = line_level_d;
	assign res.busy_res  = active_d;
	assign res.dropped   = dropped_d;

	a_idle_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (tick_count_q == '0 && queued_count_q == 2'd0))
		else $error("idle line with running timer or queued bytes");
	a_bits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bits_remaining_q <= FRAME_BITS && queued_count_q != 2'd3)
		else $error("frame bit count or queue count out of range");
	a_idle_mark: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> line_level_q)
		else $error("free line not at mark");
	a_drop_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(step && dropped_d) |=> (active_q && $stable(frame_shift_q)))
		else $error("refused request disturbed the frame");

endmodule

/* rtl/core/serial_midi_transmitter.sv */
// Serial MIDI transmitter: a tick-paced 8N1 serial transmitter for one pin.
// Input channel (in_valid / in_stall): each request is a timer tick
// (req_type 0), a raw byte (1) or a control change (2, sends three bytes:
// status 0xB0 with the channel nibble, controller and value masked to seven
// bits). Code 3 is ignored. A send request made while the line is busy is
// refused and reported through dropped.
// Output channel (out_valid / out_stall): one result per request, giving the
// pin level, logical line level, busy flag and the drop flag, as they stand
// after that request. The result is registered in the output register when
// the request is accepted. One request per cycle is taken back to back
// unless in_stall holds the input; the core's state update sets the rate.
// When the receiver stalls, a waiting result holds and in_stall is raised
// only while the output register is full and stalled.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 bit_period in
// ticks, index 1 invert_pin. Write only while no result is outstanding.
// Reset: line free at mark, bit period 32, pin inverted, no result pending.
module serial_midi_transmitter #(
	parameter int unsigned TICK_COUNTER_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       req_type,
	input  logic [7:0]                       data_byte,
	input  logic [7:0]                       channel,
	input  logic [7:0]                       controller,
	input  logic [7:0]                       ctrl_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             pin_level,
	output logic                             line_mark,
	output logic                             busy_res,
	output logic                             dropped,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [smtx_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smtx_pkg::PERIOD_W-1:0]    cfg_data
);
	import smtx_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t res_q;
	logic out_valid_q;
	logic in_accept;

	smtx_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	smtx_core #(
		.TICK_COUNTER_BITS (TICK_COUNTER_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (in_accept),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.channel    (channel),
		.controller (controller),
		.ctrl_value (ctrl_value),
		.cfg        (cfg),
		.res        (res)
	);

	// A request is taken unless a result waits on a stalled receiver.
	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign pin_level = res_q.pin_level;
	assign line_mark = res_q.line_mark;
	assign busy_res  = res_q.busy_res;
	assign dropped   = res_q.dropped;

	a_drop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.dropped) |-> res_q.busy_res)
		else $error("refused request reported on a free line");
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with empty output register");
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> out_valid_q)
		else $error("accepted request produced no result");
	a_pin_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.busy_res) |-> res_q.line_mark)
		else $error("free line reported at space");

endmodule
